[rtl/tip_pkg.sv]
// Package for the table interpolation block: status codes, divider word type
// and divider sizing. No dependencies.
package tip_pkg;

    localparam int DIV_CELLS = 5;
    localparam int DIV_STEPS = 65;
    localparam int STEP_W    = 7;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_POINTS = 1'b0;
    localparam logic CFG_GAIN   = 1'b1;

    localparam logic [31:0] GAIN_RESET = 32'd2846213;

    // word traveling along the divider chain
    typedef struct packed {
        logic              vld;
        logic [STEP_W-1:0] step;
        logic [31:0]       rem;
        logic [64:0]       dq;    // dividend bits out the top, quotient bits in the bottom
        logic [31:0]       den;
    } t_div_word;

endpackage

[rtl/tip_ifs.sv]
// Channel interfaces for the table interpolation block: request and result.
// Depends on nothing.
interface tip_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [9:0]  index;
    logic [31:0] energy;
    logic [31:0] yield_value;
    modport source (output valid, output operation, output index, output energy,
                    output yield_value, input ready);
    modport sink   (input valid, input operation, input index, input energy,
                    input yield_value, output ready);
endinterface

interface tip_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] ratio;
    logic [1:0]  status;
    modport source (output valid, output ratio, output status, input ready);
    modport sink   (input valid, input ratio, input status, output ready);
endinterface

[rtl/table_interp_per_energy.sv]
// Top level: breakpoint table, scan sequencer, multipliers, divider ring.
// Depends on tip_pkg, tip_ifs and tip_divider.
//
//  channel   dir  words
//  i_req     in   load or query: operation, index, energy, yield_value
//  o_rsp     out  ratio, status; one word per query
//  i_cfg_*   in   register writes, index 0 points_in_use, 1 gain
//
// Loads are written on accept and leave the block idle. A query scans one
// table entry per cycle from the single read port, then forms two products
// and runs a 65-step division through the 5-cell ring (13 laps), then a gain
// product and a second such division. One item at a time; i_req.ready is
// high while idle. Reset is synchronous and clears the state, the address,
// the point count and the output valid, and sets the gain to GAIN_RESET; table
// contents are kept. A stalled result holds the block before it goes idle.
module table_interp_per_energy
    import tip_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    tip_req_if.sink     i_req,
    tip_rsp_if.source   o_rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_MUL, S_SUM, S_DIV1, S_MUL2, S_ST2, S_DIV2, S_PUT
    } t_state;

    t_state      r_state;
    logic [10:0] r_points;
    logic [31:0] r_gain;

    logic [31:0] mem_e [TABLE_DEPTH];
    logic [31:0] mem_y [TABLE_DEPTH];
    logic [31:0] r_qe, r_qy;

    logic [CW-1:0] r_addr, r_j, r_n;
    logic          r_qv;
    logic [31:0]   r_e, r_pe, r_py, r_e0, r_e1, r_y0, r_y1;
    logic [63:0]   r_a, r_b, r_p;
    logic [31:0]   r_yi;
    logic [31:0]   r_ratio, r_o_ratio;
    t_status       r_status, r_o_status;
    logic          r_o_valid;

    logic [CW-1:0] n_cnt;
    logic          div_start, div_done;
    logic [64:0]   div_dividend, div_q;
    logic [31:0]   div_den;
    logic          acc, hit;

    assign acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign n_cnt = (32'(r_points) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_points);
    assign hit = (r_j != '0) && (r_pe <= r_e) && (r_qe > r_e);

    always_ff @(posedge i_clk) begin
        if (acc && (i_req.operation == OP_LOAD) && (32'(i_req.index) < 32'(TABLE_DEPTH))) begin
            mem_e[AW'(i_req.index)] <= i_req.energy;
            mem_y[AW'(i_req.index)] <= i_req.yield_value;
        end
        r_qe <= mem_e[r_addr[AW-1:0]];
        r_qy <= mem_y[r_addr[AW-1:0]];
    end

    assign div_start    = (r_state == S_SUM) || (r_state == S_ST2);
    assign div_dividend = (r_state == S_SUM) ? ({1'b0, r_a} + {1'b0, r_b})
                                             : {5'd0, r_p[63:4]};
    assign div_den      = (r_state == S_SUM) ? (r_e1 - r_e0) : r_e;

    tip_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_den),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_points  <= '0;
            r_gain    <= GAIN_RESET;
            r_o_valid <= 1'b0;
            r_addr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POINTS: r_points <= i_cfg_data[10:0];
                    CFG_GAIN:   r_gain   <= i_cfg_data;
                    default:    r_gain   <= r_gain;
                endcase
            end
            if (r_o_valid && o_rsp.ready && (r_state != S_PUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    r_j    <= '0;
                    r_qv   <= 1'b0;
                    if (acc && (i_req.operation == OP_QUERY)) begin
                        r_e <= i_req.energy;
                        r_n <= n_cnt;
                        r_ratio <= '0;
                        if (n_cnt == '0) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_PUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + CW'(1);
                    r_qv   <= 1'b1;
                    if (r_qv) begin
                        if (hit) begin
                            r_e0 <= r_pe;
                            r_e1 <= r_qe;
                            r_y0 <= r_py;
                            r_y1 <= r_qy;
                            if (r_e == '0) begin
                                r_status <= ST_ZERO;
                                r_state  <= S_PUT;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_MUL;
                            end
                        end else if (r_j == r_n - CW'(1)) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_PUT;
                        end else begin
                            r_pe <= r_qe;
                            r_py <= r_qy;
                            r_j  <= r_j + CW'(1);
                        end
                    end
                end
                S_MUL: begin
                    r_a     <= r_y1 * (r_e - r_e0);
                    r_b     <= r_y0 * (r_e1 - r_e);
                    r_state <= S_SUM;
                end
                S_SUM: r_state <= S_DIV1;
                S_DIV1: begin
                    if (div_done) begin
                        r_yi    <= div_q[31:0];
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_p     <= r_yi * r_gain;
                    r_state <= S_ST2;
                end
                S_ST2: r_state <= S_DIV2;
                S_DIV2: begin
                    if (div_done) begin
                        r_ratio <= (div_q[64:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_ratio  <= r_ratio;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid  = r_o_valid;
    assign o_rsp.ratio  = r_o_ratio;
    assign o_rsp.status = r_o_status;

endmodule

[rtl/tip_div_cell.sv]
// One restoring division step cell with a register on its output.
// Depends on tip_pkg.
module tip_div_cell
    import tip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word   r_word;
    t_div_word   n_word;
    logic [32:0] trial;

    always_comb begin
        n_word = i_word;
        trial  = {i_word.rem, i_word.dq[64]} - {1'b0, i_word.den};
        if (i_word.vld && (i_word.step < STEP_W'(DIV_STEPS))) begin
            n_word.step = i_word.step + STEP_W'(1);
            if (!trial[32]) begin
                n_word.rem = trial[31:0];
                n_word.dq  = {i_word.dq[63:0], 1'b1};
            end else begin
                n_word.rem = {i_word.rem[30:0], i_word.dq[64]};
                n_word.dq  = {i_word.dq[63:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= n_word.vld;
        end
        r_word.step <= n_word.step;
        r_word.rem  <= n_word.rem;
        r_word.dq   <= n_word.dq;
        r_word.den  <= n_word.den;
    end

    assign o_word = r_word;

endmodule

[rtl/tip_divider.sv]
// Ring of division cells: a word circulates until all 65 steps are done.
// Depends on tip_pkg and tip_div_cell.
module tip_divider
    import tip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [64:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [64:0] o_quotient
);

    t_div_word link [DIV_CELLS+1];
    t_div_word head;
    t_div_word tail;
    logic      tail_done;

    assign tail      = link[DIV_CELLS];
    assign tail_done = tail.vld && (tail.step == STEP_W'(DIV_STEPS));

    always_comb begin
        head = tail;
        if (i_start) begin
            head.vld  = 1'b1;
            head.step = '0;
            head.rem  = '0;
            head.dq   = i_dividend;
            head.den  = i_divisor;
        end else if (tail_done) begin
            head.vld = 1'b0;
        end
    end

    assign link[0] = head;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        tip_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_word (link[g]),
            .o_word (link[g+1])
        );
    end

    assign o_done     = tail_done;
    assign o_quotient = tail.dq;

endmodule

[test/tb_table_interp_per_energy.sv]
// Testbench for table_interp_per_energy: loads breakpoints, queries interpolated
// ratios and checks each result word against an in-bench interpolation predictor.
// Depends on tip_pkg, tip_ifs and the block RTL.
`timescale 1ns / 1ps

module tb_table_interp_per_energy;
    import tip_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int STALL_MAX = 20000;
    localparam int LONG_PTS  = 48;

    typedef struct packed {
        logic [31:0] ratio;
        t_status     status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [31:0] i_cfg_data;

    tip_req_if req_if();
    tip_rsp_if rsp_if();

    table_interp_per_energy #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_if.sink), .o_rsp(rsp_if.source)
    );

    logic [31:0] bp_energy [DEPTH];
    logic [31:0] bp_yield  [DEPTH];
    bit          bp_loaded [DEPTH];
    logic [10:0] points_cnt;
    logic [31:0] gain_q;

    t_answer answers_due[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;
    int      idle_cycles;
    bit      timed_out;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // bit-serial 65-bit by 32-bit quotient
    function automatic logic [64:0] quot65(logic [64:0] num, logic [31:0] den);
        logic [32:0] rem;
        logic [64:0] q;
        rem = '0;
        q = '0;
        for (int b = 64; b >= 0; b--) begin
            rem = {rem[31:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_answer interp_ratio(logic [31:0] e);
        t_answer a;
        int n;
        logic [31:0] e0, e1;
        logic [64:0] s;
        logic [31:0] y;
        logic [63:0] q;
        a.ratio = '0;
        a.status = ST_RANGE;
        n = (points_cnt > DEPTH) ? DEPTH : int'(points_cnt);
        if (n == 0) begin
            a.status = ST_EMPTY;
            return a;
        end
        for (int i = 1; i < n; i++) begin
            e0 = bp_energy[i-1];
            e1 = bp_energy[i];
            if (e0 <= e && e1 > e) begin
                if (e == 0) begin
                    a.status = ST_ZERO;
                end else begin
                    s = 65'(64'(bp_yield[i]) * 64'(e - e0))
                      + 65'(64'(bp_yield[i-1]) * 64'(e1 - e));
                    y = 32'(quot65(s, e1 - e0));
                    q = ((64'(y) * 64'(gain_q)) >> 4) / 64'(e);
                    a.ratio = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                    a.status = ST_OK;
                end
                return a;
            end
        end
        return a;
    endfunction

    // only indices below the count are ever read
    function automatic bit table_safe(int n);
        int m;
        m = (n > DEPTH) ? DEPTH : n;
        for (int i = 0; i < m; i++)
            if (!bp_loaded[i]) return 1'b0;
        return 1'b1;
    endfunction

    // valid stays high after the accept; the next send or drain drives it
    task automatic send_word(logic op, logic [9:0] idx, logic [31:0] e, logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.index       <= idx;
        req_if.energy      <= e;
        req_if.yield_value <= y;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (op == OP_LOAD) begin
            if (idx < DEPTH) begin
                bp_energy[idx] = e;
                bp_yield[idx]  = y;
                bp_loaded[idx] = 1'b1;
            end
        end else begin
            answers_due.insert(answers_due.size(), interp_ratio(e));
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POINTS) points_cnt = data[10:0];
        else gain_q = data;
    endtask

    task automatic load_ramp(int n, logic [31:0] base, logic [31:0] stepv);
        for (int i = 0; i < n; i++)
            send_word(OP_LOAD, 10'(i), base + 32'(i) * stepv, $urandom());
    endtask

    task automatic test_directed();
        send_word(OP_QUERY, '0, 32'd5, '0);
        load_ramp(4, 32'd0, 32'h0010_0000);
        write_reg(CFG_POINTS, 11'd1);
        send_word(OP_QUERY, '0, 32'd0, '0);
        write_reg(CFG_POINTS, 11'd4);
        send_word(OP_QUERY, '0, 32'd0, '0);
        send_word(OP_QUERY, '0, 32'd1, '0);
        send_word(OP_QUERY, '0, 32'h0018_0000, '0);
        send_word(OP_QUERY, '0, 32'h0030_0000, '0);
        send_word(OP_QUERY, '0, 32'hFFFF_FFFF, '0);
        send_word(OP_LOAD, 10'd1, 32'h0000_0001, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_QUERY, '0, 32'h0000_0000, '0);
        send_word(OP_LOAD, 10'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_QUERY, '0, 32'h0028_0000, '0);
        send_word(OP_QUERY, '0, 32'hFFFF_FFFE, '0);
        write_reg(CFG_GAIN, 32'hFFFF_FFFF);
        send_word(OP_QUERY, '0, 32'h0000_0002, '0);
        send_word(OP_QUERY, '0, 32'hFFFF_FFFE, '0);
        write_reg(CFG_GAIN, 32'd0);
        send_word(OP_QUERY, '0, 32'h0000_0002, '0);
        write_reg(CFG_GAIN, GAIN_RESET);
    endtask

    // count at the loaded size, then above depth: queries hit before the scan leaves the loaded entries
    task automatic test_long_table();
        for (int i = 0; i < LONG_PTS; i++)
            send_word(OP_LOAD, 10'(i), 32'(i) << 20 | 32'($urandom_range(0, 'hFFFFF)),
                      $urandom());
        write_reg(CFG_POINTS, 11'(LONG_PTS));
        send_word(OP_QUERY, '0, 32'h02F0_0000, '0);
        send_word(OP_QUERY, '0, 32'h0000_0100, '0);
        write_reg(CFG_POINTS, 11'd2047);
        send_word(OP_QUERY, '0, 32'h000F_FFFF, '0);
        send_word(OP_QUERY, '0, 32'h02E8_0000, '0);
    endtask

    task automatic test_random(int count);
        int n;
        logic [31:0] e;
        write_reg(CFG_GAIN, $urandom());
        n = $urandom_range(2, 12);
        load_ramp(n, $urandom_range(0, 'hFFFF), $urandom_range(1, 'h00FF_FFFF));
        if ($urandom_range(3) == 0)
            send_word(OP_LOAD, 10'($urandom_range(n - 1)), $urandom(), $urandom());
        write_reg(CFG_POINTS, 11'(n));
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: e = $urandom();
                1: e = bp_energy[$urandom_range(n - 1)];
                default: e = bp_energy[0] + $urandom_range(0, bp_energy[n-1] - bp_energy[0]);
            endcase
            if ($urandom_range(7) == 0) begin
                // rewrite an entry inside the used range only
                send_word(OP_LOAD, 10'($urandom_range(n - 1)), $urandom(), $urandom());
            end else begin
                send_word(OP_QUERY, 10'($urandom()), e, $urandom());
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int k = 0; k < 6; k++)
            send_word(OP_QUERY, '0, bp_energy[0] + 1, '0);
        drain();
        send_word(OP_QUERY, '0, bp_energy[1], '0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_POINTS;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.operation = OP_LOAD;
        req_if.index = '0;
        req_if.energy = '0;
        req_if.yield_value = '0;
        rsp_if.ready = 1'b0;
        points_cnt = '0;
        gain_q = GAIN_RESET;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        timed_out = 1'b0;
        foreach (bp_loaded[i]) bp_loaded[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_table();
        test_backpressure();
        test_random(75);
        send_idle_pct = 57;
        test_random(75);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        test_random(75);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random(75);
        write_reg(CFG_POINTS, 11'd0);
        send_word(OP_QUERY, '0, $urandom(), '0);
        drain();
        if (!table_safe(points_cnt)) mismatches++;
        if (mismatches == 0 && !timed_out) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_answer exp_a;
        if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word ratio=%h status=%0d",
                             rsp_if.ratio, rsp_if.status);
            end else begin
                exp_a = answers_due.pop_front();
                if (rsp_if.ratio !== exp_a.ratio || rsp_if.status !== exp_a.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ratio=%h status=%0d, got ratio=%h status=%0d",
                                 exp_a.ratio, exp_a.status, rsp_if.ratio, rsp_if.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (!req_if.valid && answers_due.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

[sim.f]
rtl/tip_pkg.sv
rtl/tip_ifs.sv
rtl/tip_div_cell.sv
rtl/tip_divider.sv
rtl/table_interp_per_energy.sv
test/tb_table_interp_per_energy.sv
